### src/csds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the column scalar diffusion stencil.
package csds_pkg;

    localparam int DW   = 32;          // width of every data field
    localparam int DIVW = 2 * DW + 1;  // divider remainder width
    localparam int NUMW = DIVW + 1;    // signed numerator width
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_VARIABLE_K = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_K      = 1'd1;

    typedef struct packed {
        logic signed [DW-1:0] sample_value;
        logic signed [DW-1:0] local_diffusivity;
        logic [DW-1:0]        layer_thickness;
        logic                 first_level;
        logic                 last_level;
    } in_item_t;

    typedef struct packed {
        logic signed [DW-1:0] tendency;
        logic                 boundary_level;
        logic                 saturated;
        logic                 last_of_column;
    } out_item_t;

    // Operand set fed to the divider
    typedef enum logic [1:0] {
        NSEL_GUP  = 2'd0,
        NSEL_GDN  = 2'd1,
        NSEL_TEND = 2'd2
    } num_sel_t;

    typedef struct packed {
        logic     capture;
        logic     restart;
        logic     push;
        logic     load_k;
        logic     div_start;
        num_sel_t div_sel;
        logic     save_gup;
        logic     save_gdn;
        logic     save_t;
        logic     mul_up;
        logic     mul_dn;
        logic     flux_dn;
        logic     emit_int;
        logic     emit_bnd;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_first;
        logic in_last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

### src/column_scalar_diffusion_stencil_top.sv
`timescale 1ns / 1ps
// Top level of the column scalar diffusion stencil: controller plus datapath.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-----------------------------------
//  item     | item_valid / item_stall       | csds_pkg::in_item_t, one level
//  result   | result_valid / result_stall   | csds_pkg::out_item_t, one level
//  cfg      | cfg_write_en (no wait)        | cfg_index, cfg_data
//
// A boundary-only level goes from dispatch straight to its emit state; an
// interior level makes three passes through the shared radix-2 divider (one
// quotient bit per cycle plus setup each) and two products on the single
// flux multiplier. One level is in flight at a time.
// Reset (rst_n, asynchronous, active low) empties the window and clears the
// config registers. The result register lets a transfer wait under
// result_stall while the next level is already accepted.
module column_scalar_diffusion_stencil_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  csds_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output csds_pkg::out_item_t                 result,
    input  logic                                cfg_write_en,
    input  logic [csds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csds_pkg::DW-1:0]             cfg_data
);

    // command and status between the sequencer and the datapath
    csds_pkg::ctrl_cmd_t  cmd;
    csds_pkg::dp_status_t status;

    // Sequencer: tracks the open column and steps through the divide,
    // multiply and emit operations for each level.
    csds_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: holds the two-level window, runs gradients, fluxes and the
    // tendency, and drives the result register.
    csds_datapath #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

### src/csds_div.sv
`timescale 1ns / 1ps
// Radix-2 fixed-point divider: clamp((num << F) / den), truncated toward zero.
module csds_div #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [csds_pkg::NUMW-1:0]    num,
    input  logic [csds_pkg::DW-1:0]             den,
    output logic                                done,
    output logic signed [csds_pkg::DW-1:0]      quotient,
    output logic                                sat
);

    localparam int CNT_W = $clog2(csds_pkg::DW);

    typedef enum logic [4:0] {
        D_IDLE  = 5'b00001,
        D_ABS   = 5'b00010,
        D_CHECK = 5'b00100,
        D_ITER  = 5'b01000,
        D_DONE  = 5'b10000
    } div_state_t;

    div_state_t                         state_reg, state_next;
    logic signed [csds_pkg::NUMW-1:0]   num_reg;
    logic [csds_pkg::DW-1:0]            den_reg;
    logic [csds_pkg::DIVW-1:0]          rem_reg, rem_next;
    logic [csds_pkg::DIVW-1:0]          dsh_reg, dsh_next;
    logic [csds_pkg::DW-1:0]            q_reg, q_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic                               neg_reg, neg_next;
    logic                               sat_reg, sat_next;
    logic [csds_pkg::NUMW-1:0]          mag;
    logic [csds_pkg::DIVW-1:0]          lim;

    always_comb
    begin
        mag = num_reg[csds_pkg::NUMW-1] ? csds_pkg::NUMW'(-num_reg)
                                        : csds_pkg::NUMW'(num_reg);
        lim = (csds_pkg::DIVW'(den_reg) << (csds_pkg::DW - 1))
            + (neg_reg ? csds_pkg::DIVW'(den_reg) : '0);
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        case (state_reg)
            D_ABS:
            begin
                rem_next   = csds_pkg::DIVW'(mag) << FRACTION_BITS;
                neg_next   = num_reg[csds_pkg::NUMW-1];
                state_next = D_CHECK;
            end
            D_CHECK:
            begin
                if (rem_reg >= lim)
                begin
                    // out of range: clamp to the signed limit
                    sat_next   = 1'b1;
                    q_next     = neg_reg ? {1'b1, {(csds_pkg::DW-1){1'b0}}}
                                         : {1'b0, {(csds_pkg::DW-1){1'b1}}};
                    state_next = D_DONE;
                end
                else
                begin
                    sat_next   = 1'b0;
                    q_next     = '0;
                    dsh_next   = csds_pkg::DIVW'(den_reg) << (csds_pkg::DW - 1);
                    cnt_next   = CNT_W'(csds_pkg::DW - 1);
                    state_next = D_ITER;
                end
            end
            D_ITER:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[csds_pkg::DW-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[csds_pkg::DW-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = D_ABS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
    end

    assign done     = (state_reg == D_DONE);
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign sat      = sat_reg;

endmodule

### src/csds_datapath.sv
`timescale 1ns / 1ps
// Datapath: level window, config registers, divider, flux multiplier, result register.
module csds_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csds_pkg::in_item_t                  item,
    output csds_pkg::out_item_t                 result,
    output logic                                result_valid,
    input  logic                                result_stall,
    input  logic                                cfg_write_en,
    input  logic [csds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csds_pkg::DW-1:0]             cfg_data,
    input  csds_pkg::ctrl_cmd_t                 cmd,
    output csds_pkg::dp_status_t                status
);

    localparam int DW   = csds_pkg::DW;
    localparam int NUMW = csds_pkg::NUMW;

    csds_pkg::in_item_t         in_reg;
    logic signed [DW-1:0]       win_val_reg [2];
    logic [DW-1:0]              win_k_reg   [2];
    logic [DW-1:0]              win_dz_reg  [2];
    logic                       use_var_reg;
    logic [DW-1:0]              def_k_reg;
    logic [DW-1:0]              kavg_up_reg, kavg_dn_reg;
    logic signed [DW-1:0]       g_up_reg, g_dn_reg, t_reg;
    logic                       sat_reg;
    logic [2*DW-1:0]            prod_reg;
    logic                       prod_neg_reg;
    logic signed [NUMW-1:0]     f_up_reg, f_dn_reg;
    logic                       out_valid_reg, out_valid_next;
    csds_pkg::out_item_t        out_reg;

    logic [DW-1:0]              k_m, k_0, k_p;
    logic [DW:0]                sum_up, sum_dn;
    logic signed [NUMW-1:0]     div_num;
    logic [DW-1:0]              den_raw, div_den;
    logic                       div_done, div_sat;
    logic signed [DW-1:0]       div_q;
    logic [DW-1:0]              mul_a;
    logic signed [DW-1:0]       mul_g;
    logic [DW-1:0]              mul_mag;
    logic [NUMW-1:0]            p_ext;
    logic signed [NUMW-1:0]     flux_val;
    logic                       out_free;

    function automatic logic [csds_pkg::DW-1:0] eff_k(
        input logic [csds_pkg::DW-1:0] raw,
        input logic                    use_var,
        input logic [csds_pkg::DW-1:0] dflt
    );
        if (!use_var)
        begin
            return dflt;
        end
        // negative diffusivity clamps to zero
        return raw[csds_pkg::DW-1] ? '0 : raw;
    endfunction

    // averaged diffusivities
    always_comb
    begin
        k_m    = eff_k(win_k_reg[0], use_var_reg, def_k_reg);
        k_0    = eff_k(win_k_reg[1], use_var_reg, def_k_reg);
        k_p    = eff_k(in_reg.local_diffusivity, use_var_reg, def_k_reg);
        sum_up = {1'b0, k_0} + {1'b0, k_m};
        sum_dn = {1'b0, k_0} + {1'b0, k_p};
    end

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            csds_pkg::NSEL_GUP:
            begin
                div_num = NUMW'(win_val_reg[1]) - NUMW'(win_val_reg[0]);
                den_raw = win_dz_reg[0];
            end
            csds_pkg::NSEL_GDN:
            begin
                div_num = NUMW'(in_reg.sample_value) - NUMW'(win_val_reg[1]);
                den_raw = in_reg.layer_thickness;
            end
            csds_pkg::NSEL_TEND:
            begin
                div_num = f_dn_reg - f_up_reg;
                den_raw = win_dz_reg[1];
            end
            default:
            begin
                div_num = '0;
                den_raw = '0;
            end
        endcase
        // zero thickness counts as one LSB
        div_den = (den_raw == '0) ? DW'(1) : den_raw;
    end

    csds_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q),
        .sat      (div_sat)
    );

    // flux multiplier operands and product scaling
    always_comb
    begin
        mul_a    = cmd.mul_up ? kavg_up_reg : kavg_dn_reg;
        mul_g    = cmd.mul_up ? g_up_reg : g_dn_reg;
        mul_mag  = mul_g[DW-1] ? DW'(-mul_g) : DW'(mul_g);
        p_ext    = NUMW'(prod_reg >> FRACTION_BITS);
        flux_val = prod_neg_reg ? -$signed(p_ext) : $signed(p_ext);
    end

    always_comb
    begin
        out_free       = !out_valid_reg || !result_stall;
        out_valid_next = out_valid_reg;
        if (cmd.emit_int || cmd.emit_bnd)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            use_var_reg   <= 1'b0;
            def_k_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    csds_pkg::CFG_USE_VARIABLE_K: use_var_reg <= cfg_data[0];
                    csds_pkg::CFG_DEFAULT_K:      def_k_reg   <= cfg_data;
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= item;
        end
        if (cmd.restart)
        begin
            win_val_reg[0] <= '0;
            win_k_reg[0]   <= '0;
            win_dz_reg[0]  <= '0;
        end
        else if (cmd.push)
        begin
            win_val_reg[0] <= win_val_reg[1];
            win_k_reg[0]   <= win_k_reg[1];
            win_dz_reg[0]  <= win_dz_reg[1];
        end
        if (cmd.restart || cmd.push)
        begin
            win_val_reg[1] <= in_reg.sample_value;
            win_k_reg[1]   <= in_reg.local_diffusivity;
            win_dz_reg[1]  <= in_reg.layer_thickness;
        end
        if (cmd.load_k)
        begin
            kavg_up_reg <= sum_up[DW:1];
            kavg_dn_reg <= sum_dn[DW:1];
        end
        if (cmd.save_gup)
        begin
            g_up_reg <= div_q;
            sat_reg  <= div_sat;
        end
        if (cmd.save_gdn)
        begin
            g_dn_reg <= div_q;
            sat_reg  <= sat_reg | div_sat;
        end
        if (cmd.save_t)
        begin
            t_reg   <= div_q;
            sat_reg <= sat_reg | div_sat;
        end
        if (cmd.mul_up || cmd.mul_dn)
        begin
            prod_reg     <= (2*DW)'(mul_a) * (2*DW)'(mul_mag);
            prod_neg_reg <= mul_g[DW-1];
        end
        if (cmd.mul_dn)
        begin
            f_up_reg <= flux_val;
        end
        if (cmd.flux_dn)
        begin
            f_dn_reg <= flux_val;
        end
        if (cmd.emit_int)
        begin
            out_reg.tendency       <= t_reg;
            out_reg.boundary_level <= 1'b0;
            out_reg.saturated      <= sat_reg;
            out_reg.last_of_column <= 1'b0;
        end
        else if (cmd.emit_bnd)
        begin
            out_reg.tendency       <= '0;
            out_reg.boundary_level <= 1'b1;
            out_reg.saturated      <= 1'b0;
            out_reg.last_of_column <= in_reg.last_level;
        end
    end

    assign result          = out_reg;
    assign result_valid    = out_valid_reg;
    assign status.in_first = in_reg.first_level;
    assign status.in_last  = in_reg.last_level;
    assign status.div_done = div_done;
    assign status.out_free = out_free;

endmodule

### src/csds_ctrl.sv
`timescale 1ns / 1ps
// Controller: column tracking and per-level operation sequence.
module csds_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  csds_pkg::dp_status_t    status,
    output csds_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DISPATCH = 11'b00000000010,
        S_DIV_UP   = 11'b00000000100,
        S_DIV_DN   = 11'b00000001000,
        S_MUL_UP   = 11'b00000010000,
        S_MUL_DN   = 11'b00000100000,
        S_FLUX     = 11'b00001000000,
        S_START_T  = 11'b00010000000,
        S_DIV_T    = 11'b00100000000,
        S_EMIT_I   = 11'b01000000000,
        S_EMIT_B   = 11'b10000000000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic [1:0]  seen_reg, seen_next;

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.in_first || seen_reg == 2'd0)
                begin
                    // open a new column, dropping any open one
                    cmd.restart = 1'b1;
                    seen_next   = status.in_last ? 2'd0 : 2'd1;
                    state_next  = S_EMIT_B;
                end
                else if (seen_reg == 2'd2)
                begin
                    cmd.load_k    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = csds_pkg::NSEL_GUP;
                    seen_next     = status.in_last ? 2'd0 : 2'd2;
                    state_next    = S_DIV_UP;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    seen_next  = status.in_last ? 2'd0 : 2'd2;
                    state_next = status.in_last ? S_EMIT_B : S_IDLE;
                end
            end
            S_DIV_UP:
            begin
                if (status.div_done)
                begin
                    cmd.save_gup  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = csds_pkg::NSEL_GDN;
                    state_next    = S_DIV_DN;
                end
            end
            S_DIV_DN:
            begin
                if (status.div_done)
                begin
                    cmd.save_gdn = 1'b1;
                    state_next   = S_MUL_UP;
                end
            end
            S_MUL_UP:
            begin
                cmd.mul_up = 1'b1;
                state_next = S_MUL_DN;
            end
            S_MUL_DN:
            begin
                cmd.mul_dn = 1'b1;
                state_next = S_FLUX;
            end
            S_FLUX:
            begin
                cmd.flux_dn = 1'b1;
                state_next  = S_START_T;
            end
            S_START_T:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = csds_pkg::NSEL_TEND;
                state_next    = S_DIV_T;
            end
            S_DIV_T:
            begin
                if (status.div_done)
                begin
                    cmd.save_t = 1'b1;
                    state_next = S_EMIT_I;
                end
            end
            S_EMIT_I:
            begin
                if (status.out_free)
                begin
                    cmd.emit_int = 1'b1;
                    cmd.push     = 1'b1;
                    state_next   = status.in_last ? S_EMIT_B : S_IDLE;
                end
            end
            S_EMIT_B:
            begin
                if (status.out_free)
                begin
                    cmd.emit_bnd = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the column scalar diffusion stencil, with a predictor and checker.
module tb_top;

    localparam int DW = csds_pkg::DW;
    localparam int FRAC_BITS = 16;
    // Pause after the last expected result. It lets a level that causes no
    // result leave the block before the registers change.
    localparam int SETTLE_CYCLES = 150;
    // Watchdog bound, set well above the slowest correct run, in which each
    // level adds its compute, a driver gap and its stalled results.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_LEVELS_PER_SETTING = 92;
    localparam longint TEND_MAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint TEND_MIN = -TEND_MAX - 1;

    // Clock, reset and block ports; every input is known from time zero
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    csds_pkg::in_item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    csds_pkg::out_item_t result;
    logic cfg_write_en = 1'b0;
    logic [csds_pkg::CFG_IDX_W-1:0] cfg_index = csds_pkg::CFG_USE_VARIABLE_K;
    logic [DW-1:0] cfg_data = '0;

    // Levels waiting to be driven, and results still owed by the block
    csds_pkg::in_item_t level_feed[$];
    csds_pkg::out_item_t expected_tendencies[$];

    // Predictor copy of the configuration and the two-level window
    bit variable_k_on = 1'b0;
    logic [DW-1:0] default_k = '0;
    logic [DW-1:0] win_phi[2] = '{default: '0};
    logic [DW-1:0] win_k[2] = '{default: '0};
    logic [DW-1:0] win_dz[2] = '{default: '0};
    int unsigned open_levels = 0;

    // Run statistics and failure bookkeeping
    int unsigned cycle_count = 0;
    int unsigned levels_sent = 0;
    int unsigned results_checked = 0;
    int unsigned interior_seen = 0;
    int unsigned saturated_seen = 0;
    int unsigned settings_used = 0;
    int unsigned errors = 0;

    column_scalar_diffusion_stencil_top #(
        .FRACTION_BITS(FRAC_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------

    // Zero thickness counts as one LSB.
    function automatic longint unsigned spacing(input logic [DW-1:0] dz);
        return (dz == '0) ? 64'd1 : {32'd0, dz};
    endfunction

    // Variable mode clamps negative diffusivity to zero; otherwise use the register.
    function automatic longint unsigned effective_k(input logic [DW-1:0] raw);
        if (!variable_k_on)
            return {32'd0, default_k};
        if (raw[DW-1])
            return 64'd0;
        return {32'd0, raw};
    endfunction

    // num * 2^F / den, truncated toward zero, clamped to the signed data range.
    function automatic longint scaled_div(input longint num, input longint unsigned den,
                                          inout bit clamped);
        bit neg;
        longint unsigned mag;
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned res;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        quo = mag / den;
        rem = mag % den;
        if (quo >= (64'd1 << (DW - 1)))
        begin
            clamped = 1'b1;
            return neg ? TEND_MIN : TEND_MAX;
        end
        res = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / den);
        if (!neg && res > longint'(TEND_MAX))
        begin
            clamped = 1'b1;
            return TEND_MAX;
        end
        if (neg && res > longint'(TEND_MAX) + 1)
        begin
            clamped = 1'b1;
            return TEND_MIN;
        end
        return neg ? -longint'(res) : longint'(res);
    endfunction

    // (kavg * grad) >> F, truncated toward zero.
    function automatic longint layer_flux(input longint unsigned kavg, input longint grad);
        bit neg;
        longint unsigned mag;
        longint unsigned prod;
        neg = grad < 0;
        mag = neg ? longint'(-grad) : longint'(grad);
        prod = (kavg * mag) >> FRAC_BITS;
        return neg ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic csds_pkg::out_item_t boundary_result(input bit closes);
        csds_pkg::out_item_t r;
        r = '0;
        r.boundary_level = 1'b1;
        r.last_of_column = closes;
        return r;
    endfunction

    // Advance the window by one level and queue the results it causes.
    task automatic predict_level(input csds_pkg::in_item_t lvl);
        csds_pkg::out_item_t r;
        bit clamped;
        longint phi_m;
        longint phi_0;
        longint phi_p;
        longint g_up;
        longint g_dn;
        longint f_up;
        longint f_dn;
        longint unsigned k_m;
        longint unsigned k_0;
        longint unsigned k_p;
        bit opens;
        opens = lvl.first_level || open_levels == 0;
        // Interior result for the level above, once two levels are held
        if (!opens && open_levels >= 2)
        begin
            clamped = 1'b0;
            phi_m = longint'($signed(win_phi[0]));
            phi_0 = longint'($signed(win_phi[1]));
            phi_p = longint'(lvl.sample_value);
            k_m = effective_k(win_k[0]);
            k_0 = effective_k(win_k[1]);
            k_p = effective_k(lvl.local_diffusivity);
            g_up = scaled_div(phi_0 - phi_m, spacing(win_dz[0]), clamped);
            g_dn = scaled_div(phi_p - phi_0, spacing(lvl.layer_thickness), clamped);
            f_up = layer_flux((k_0 + k_m) >> 1, g_up);
            f_dn = layer_flux((k_0 + k_p) >> 1, g_dn);
            r = '0;
            r.tendency = DW'(scaled_div(f_dn - f_up, spacing(win_dz[1]), clamped));
            r.saturated = clamped;
            expected_tendencies.push_back(r);
        end
        win_phi[0] = win_phi[1];
        win_k[0] = win_k[1];
        win_dz[0] = win_dz[1];
        win_phi[1] = lvl.sample_value;
        win_k[1] = lvl.local_diffusivity;
        win_dz[1] = lvl.layer_thickness;
        if (opens)
        begin
            // Top level (or a stray level, or a restart): boundary result at once
            expected_tendencies.push_back(boundary_result(lvl.last_level));
            open_levels = lvl.last_level ? 0 : 1;
        end
        else
        begin
            open_levels = (open_levels >= 2) ? 2 : open_levels + 1;
            if (lvl.last_level)
            begin
                expected_tendencies.push_back(boundary_result(1'b1));
                open_levels = 0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic csds_pkg::in_item_t make_level(
        input logic [DW-1:0] phi,
        input logic [DW-1:0] k,
        input logic [DW-1:0] dz,
        input bit            first,
        input bit            last
    );
        csds_pkg::in_item_t lvl;
        lvl.sample_value = phi;
        lvl.local_diffusivity = k;
        lvl.layer_thickness = dz;
        lvl.first_level = first;
        lvl.last_level = last;
        return lvl;
    endfunction

    function automatic logic [DW-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Mostly small values around the origin, some full range, some extremes
    function automatic logic [DW-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return pick_extreme();
            1, 2, 3: return $urandom;
            default: return DW'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_k();
        case ($urandom_range(0, 9))
            6: return $urandom;
            7: return DW'(-int'($urandom_range(1, 1 << 16)));
            8: return pick_extreme();
            9: return $urandom_range(0, 32'h7FFF_FFFF);
            default: return $urandom_range(0, 4 << 16);
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_thickness();
        case ($urandom_range(0, 9))
            6: return $urandom;
            7:
            begin
                case ($urandom_range(0, 2))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            8, 9: return $urandom_range(1, 32'h800);
            default: return $urandom_range(32'h4000, 32'h4_0000);
        endcase
    endfunction

    task automatic queue_column(input int depth, input bit mark_first, input bit mark_last);
        for (int i = 0; i < depth; i++)
            level_feed.push_back(make_level(rand_value(), rand_k(), rand_thickness(),
                                            mark_first && i == 0,
                                            mark_last && i == depth - 1));
    endtask

    // Mostly well-formed columns with random content; the rest drop a mark or
    // are single levels with random marks.
    task automatic queue_random_levels(input int count);
        int queued;
        int depth;
        int kind;
        queued = 0;
        while (queued < count)
        begin
            kind = $urandom_range(0, 19);
            depth = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : $urandom_range(3, 8);
            if (kind >= 18)
            begin
                level_feed.push_back(make_level(rand_value(), rand_k(), rand_thickness(),
                                                $urandom_range(0, 1), $urandom_range(0, 1)));
                depth = 1;
            end
            else
                queue_column(depth, kind != 16, kind != 17);
            queued += depth;
        end
    endtask

    task automatic queue_directed_levels();
        // Single-level column at the value extreme, zero thickness, negative K
        level_feed.push_back(make_level(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, 1));
        // Level with no open column and no first mark, closing at once
        level_feed.push_back(make_level(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 0, 1));
        // Two-level column: both boundary results
        level_feed.push_back(make_level(32'h0, 32'h7FFF_FFFF, 32'h1, 1, 0));
        level_feed.push_back(make_level(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF, 0, 1));
        // Alternating extremes on unit-LSB spacing make the stages clamp; the column ends on zero and maximal thickness
        level_feed.push_back(make_level(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 1, 0));
        level_feed.push_back(make_level(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 0, 0));
        level_feed.push_back(make_level(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 0, 0));
        level_feed.push_back(make_level(32'h0, 32'h8000_0000, 32'h0, 0, 0));
        level_feed.push_back(make_level(32'h0, 32'hFFFF_0000, 32'hFFFF_FFFF, 0, 0));
        level_feed.push_back(make_level(32'h0001_2345, 32'h0002_0000, 32'hFFFF_FFFF, 0, 1));
        // Ordinary column, then a first mark inside it restarts without closing
        level_feed.push_back(make_level(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1, 0));
        level_feed.push_back(make_level(32'h0001_0000, 32'h0001_8000, 32'h0000_8000, 0, 0));
        level_feed.push_back(make_level(32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000, 0, 0));
        level_feed.push_back(make_level(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 1, 0));
        level_feed.push_back(make_level(32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 0, 0));
        level_feed.push_back(make_level(32'hFFFE_0000, 32'h0003_0000, 32'h0001_0000, 0, 1));
        // Column opened by a level without a first mark
        level_feed.push_back(make_level(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0, 0));
        level_feed.push_back(make_level(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 0, 0));
        level_feed.push_back(make_level(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0, 0));
        level_feed.push_back(make_level(32'h5555_5555, 32'h2AAA_AAAA, 32'hAAAA_AAAA, 0, 1));
    endtask

    // ------------------------------------------------------------------
    // Configuration and sequencing helpers
    // ------------------------------------------------------------------

    // One write per call; the predictor copy is updated as the write is driven.
    task automatic write_register(input logic [csds_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [DW-1:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == csds_pkg::CFG_USE_VARIABLE_K)
            variable_k_on = data[0];
        else if (idx == csds_pkg::CFG_DEFAULT_K)
            default_k = data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic apply_setting(input bit variable_mode, input logic [DW-1:0] k_value);
        write_register(csds_pkg::CFG_USE_VARIABLE_K, {31'd0, variable_mode});
        write_register(csds_pkg::CFG_DEFAULT_K, k_value);
        settings_used++;
    endtask

    // Hold until every level has been accepted and every result checked, let
    // the block settle, and look again: the last pop and the valid update land
    // on the same edge, so one look alone can come too early.
    task automatic wait_until_idle();
        do
        begin
            while (level_feed.size() != 0 || item_valid || item_stall
                   || expected_tendencies.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (level_feed.size() != 0 || item_valid || item_stall
               || expected_tendencies.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Level driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------

    int burst_left = 0;
    int gap_left = 0;

    function automatic int pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 0;
            4, 5, 6: return $urandom_range(1, 4);
            7, 8: return $urandom_range(5, 40);
            default: return $urandom_range(40, 140);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            // Predict on the transfer itself, so the expectation is queued in order
            if (item_valid && !item_stall)
            begin
                predict_level(item);
                levels_sent++;
            end
            // Advance only when the current level has gone or none is offered;
            // a stalled level holds valid and payload unchanged.
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (level_feed.size() != 0)
                begin
                    item <= level_feed.pop_front();
                    item_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = pick_gap();
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stall pattern: the stall rate is drawn anew periodically from
    // none, light, medium and heavy, and each stall lasts a random stretch.
    // ------------------------------------------------------------------

    int stall_pct = 0;
    int stall_hold = 0;
    int unsigned stall_epoch = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            stall_epoch++;
            if (stall_epoch % 2048 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            if (stall_hold > 0)
            begin
                stall_hold--;
                result_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_hold = $urandom_range(0, 30);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        csds_pkg::out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (expected_tendencies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: tendency %h boundary %b sat %b last %b",
                             result.tendency, result.boundary_level, result.saturated,
                             result.last_of_column);
            end
            else
            begin
                want = expected_tendencies.pop_front();
                if (!want.boundary_level)
                    interior_seen++;
                if (want.saturated)
                    saturated_seen++;
                if (result.tendency !== want.tendency
                    || result.boundary_level !== want.boundary_level
                    || result.saturated !== want.saturated
                    || result.last_of_column !== want.last_of_column)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"result mismatch: expected tendency %h boundary %b sat %b ",
                                  "last %b, got tendency %h boundary %b sat %b last %b"},
                                 want.tendency, want.boundary_level, want.saturated,
                                 want.last_of_column, result.tendency, result.boundary_level,
                                 result.saturated, result.last_of_column);
                end
            end
        end
    end

    // Watchdog: drop the run if the block stops making progress
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_tendencies.size());
            $display("[column_scalar_diffusion_stencil_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed levels, then random levels under several
    // register settings, each written while the block is idle.
    // ------------------------------------------------------------------

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part in variable mode, so negative K clamping is exercised
        apply_setting(1'b1, 32'h0000_0000);
        queue_directed_levels();
        wait_until_idle();

        // Random part across settings, extremes of both registers included
        apply_setting(1'b0, 32'h0001_0000);
        queue_random_levels(RANDOM_LEVELS_PER_SETTING);
        wait_until_idle();

        apply_setting(1'b1, 32'hFFFF_FFFF);
        queue_random_levels(RANDOM_LEVELS_PER_SETTING);
        wait_until_idle();

        apply_setting(1'b0, 32'hFFFF_FFFF);
        queue_random_levels(RANDOM_LEVELS_PER_SETTING);
        wait_until_idle();

        apply_setting(1'b0, 32'h0000_0000);
        queue_random_levels(RANDOM_LEVELS_PER_SETTING);
        wait_until_idle();

        apply_setting(1'b0, $urandom);
        queue_random_levels(RANDOM_LEVELS_PER_SETTING);
        wait_until_idle();

        apply_setting(1'b1, $urandom_range(0, 4 << 16));
        queue_random_levels(RANDOM_LEVELS_PER_SETTING);
        wait_until_idle();

        $display("covered %0d levels under %0d register settings in %0d cycles",
                 levels_sent, settings_used, cycle_count);
        $display("checked %0d results: %0d interior, %0d saturated, %0d failures",
                 results_checked, interior_seen, saturated_seen, errors);
        if (errors == 0)
            $display("[column_scalar_diffusion_stencil_top] OK");
        else
            $display("[column_scalar_diffusion_stencil_top] ERROR");
        $finish;
    end

endmodule
